// ===== src/vtpd_pkg.sv =====
package vtpd_pkg;

   localparam int NUM_REGS   = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;
   localparam int VAL_W      = 32;
   localparam int FRAC_W     = 16;
   localparam int PROD_W     = 2 * VAL_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int NUM_W      = VAL_W + FRAC_W;
   localparam int DIV_BITS   = NUM_W;
   localparam int DIV_STAGES = DIV_BITS + 1;

   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic [CSR_DATA_W-1:0] csr_word_type;
   typedef val_type row_type [4];

   localparam csr_word_type REG_RESET [NUM_REGS] = '{
      64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
      64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
   };

   typedef struct packed {
      logic [VAL_W-1:0] rem;
      logic [NUM_W-1:0] quo;
      logic [NUM_W-1:0] num;
      logic [VAL_W-1:0] den;
      logic             neg;
      val_type          raw;
   } div_stage_type;

endpackage

// ===== src/vtpd_if.sv =====
interface vtpd_req_if;
   import vtpd_pkg::*;
   logic    valid;
   logic    ready;
   val_type in_x;
   val_type in_y;
   val_type in_z;
   val_type in_w;
   modport source (output valid, in_x, in_y, in_z, in_w, input ready);
   modport sink (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

interface vtpd_rsp_if;
   import vtpd_pkg::*;
   logic    valid;
   logic    ready;
   val_type out_x;
   val_type out_y;
   val_type out_z;
   val_type out_w;
   logic    was_divided;
   modport source (output valid, out_x, out_y, out_z, out_w, was_divided, input ready);
   modport sink (input valid, out_x, out_y, out_z, out_w, was_divided, output ready);
endinterface

// ===== src/vtpd_dot_lane.sv =====
module vtpd_dot_lane (
   input  logic              clock,
   input  logic [1:0]        en,
   input  vtpd_pkg::row_type row,
   input  vtpd_pkg::row_type vec,
   output vtpd_pkg::val_type dot
);
   import vtpd_pkg::*;

   logic signed [PROD_W-1:0] prod_ff [4];
   logic signed [SUM_W-1:0]  sum;
   val_type                  dot_ff;
   val_type                  dot_in;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int c = 0; c < 4; c++) prod_ff[c] <= row[c] * vec[c];
      end
      if (en[1]) dot_ff <= dot_in;
   end

   always_comb begin
      sum = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2])
          + SUM_W'(prod_ff[3]);
      // floor shift, then clamp when the upper bits disagree with the sign
      if (sum[SUM_W-1] && !(&sum[SUM_W-1:FRAC_W+VAL_W-1]))
         dot_in = {1'b1, {(VAL_W-1){1'b0}}};
      else if (!sum[SUM_W-1] && (|sum[SUM_W-1:FRAC_W+VAL_W-1]))
         dot_in = {1'b0, {(VAL_W-1){1'b1}}};
      else
         dot_in = sum[FRAC_W+VAL_W-1:FRAC_W];
   end

   assign dot = dot_ff;
endmodule

// ===== src/vtpd_div_lane.sv =====
module vtpd_div_lane (
   input  logic                              clock,
   input  logic [vtpd_pkg::DIV_STAGES-1:0]   en,
   input  vtpd_pkg::val_type                 num,
   input  vtpd_pkg::val_type                 den,
   output vtpd_pkg::div_stage_type           res
);
   import vtpd_pkg::*;

   div_stage_type st_ff [DIV_STAGES];
   div_stage_type st_in [DIV_STAGES];
   logic [VAL_W-1:0] num_mag;
   logic [VAL_W-1:0] den_mag;

   assign num_mag = num[VAL_W-1] ? (~num + 1'b1) : num;
   assign den_mag = den[VAL_W-1] ? (~den + 1'b1) : den;

   always_comb begin
      st_in[0].rem = '0;
      st_in[0].quo = '0;
      st_in[0].num = {num_mag, {FRAC_W{1'b0}}};
      st_in[0].den = den_mag;
      st_in[0].neg = num[VAL_W-1] ^ den[VAL_W-1];
      st_in[0].raw = num;
   end

   // one restoring quotient bit per stage
   for (genvar k = 1; k < DIV_STAGES; k++) begin : g_step
      logic [VAL_W:0] trial;
      logic [VAL_W:0] diff;
      always_comb begin
         trial    = {st_ff[k-1].rem, st_ff[k-1].num[NUM_W-1]};
         diff     = trial - {1'b0, st_ff[k-1].den};
         st_in[k] = st_ff[k-1];
         st_in[k].num = {st_ff[k-1].num[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, st_ff[k-1].den}) begin
            st_in[k].rem = diff[VAL_W-1:0];
            st_in[k].quo = {st_ff[k-1].quo[NUM_W-2:0], 1'b1};
         end else begin
            st_in[k].rem = trial[VAL_W-1:0];
            st_in[k].quo = {st_ff[k-1].quo[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (en[k]) st_ff[k] <= st_in[k];
      end
   end

   assign res = st_ff[DIV_STAGES-1];
endmodule

// ===== src/vertex_transform_perspective_divide_unit.sv =====
// each accepted item passes through 52 register stages: product, sum and clamp,
// 49 divider stages, output
// throughput: one item per cycle unless the output stalls; four multiply lanes and
// three 49-stage dividers, a load stage then one quotient bit per stage
// each stage holds its item until the next stage is free, so bubbles close up under stall
// reset (synchronous, active high) empties the pipeline and loads the identity matrix
module vertex_transform_perspective_divide_unit (
   input  logic                          clock,
   input  logic                          reset,
   vtpd_req_if.sink                      req_chan,
   vtpd_rsp_if.source                    rsp_chan,
   input  logic                          csr_we,
   input  logic [vtpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vtpd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import vtpd_pkg::*;

   localparam int NST = DIV_STAGES + 3;

   csr_word_type  regs_ff [NUM_REGS];
   logic [NST-1:0] vld_ff;
   logic [NST:0]   adv;
   row_type        mat [4];
   row_type        vec;
   val_type        dot [4];
   div_stage_type  dres [3];
   val_type        w_ff [DIV_STAGES];
   val_type        out_in [3];
   val_type        out_ff [3];
   val_type        outw_ff;
   logic           div_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= REG_RESET[i];
      end else if (csr_we && (csr_index < CSR_IDX_W'(NUM_REGS))) begin
         regs_ff[csr_index[2:0]] <= csr_wdata;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            mat[r][c] = (c % 2 == 0) ? regs_ff[r*2 + c/2][63:32] : regs_ff[r*2 + c/2][31:0];
         end
      end
      vec[0] = req_chan.in_x;
      vec[1] = req_chan.in_y;
      vec[2] = req_chan.in_z;
      vec[3] = req_chan.in_w;
   end

   // a stage loads when it is empty or its item moves on
   always_comb begin
      adv[NST] = rsp_chan.ready;
      for (int i = NST - 1; i >= 0; i--) adv[i] = !vld_ff[i] || adv[i+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= req_chan.valid;
         for (int i = 1; i < NST; i++) begin
            if (adv[i]) vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   for (genvar r = 0; r < 4; r++) begin : g_dot
      vtpd_dot_lane u_dot (
         .clock (clock),
         .en    (adv[1:0]),
         .row   (mat[r]),
         .vec   (vec),
         .dot   (dot[r])
      );
   end

   for (genvar l = 0; l < 3; l++) begin : g_div
      vtpd_div_lane u_div (
         .clock (clock),
         .en    (adv[DIV_STAGES+1:2]),
         .num   (dot[l]),
         .den   (dot[3]),
         .res   (dres[l])
      );
   end

   always_ff @(posedge clock) begin
      if (adv[2]) w_ff[0] <= dot[3];
      for (int k = 1; k < DIV_STAGES; k++) begin
         if (adv[k+2]) w_ff[k] <= w_ff[k-1];
      end
   end

   // merge: sign and clamp each quotient, or pass the raw value when w is zero
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (w_ff[DIV_STAGES-1] == '0)
            out_in[l] = dres[l].raw;
         else if (!dres[l].neg)
            out_in[l] = (dres[l].quo > NUM_W'({1'b0, {(VAL_W-1){1'b1}}}))
                      ? {1'b0, {(VAL_W-1){1'b1}}} : dres[l].quo[VAL_W-1:0];
         else
            out_in[l] = (dres[l].quo > NUM_W'({1'b1, {(VAL_W-1){1'b0}}}))
                      ? {1'b1, {(VAL_W-1){1'b0}}} : (~dres[l].quo[VAL_W-1:0] + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NST-1]) begin
         out_ff  <= out_in;
         outw_ff <= w_ff[DIV_STAGES-1];
         div_ff  <= (w_ff[DIV_STAGES-1] != '0);
      end
   end

   assign req_chan.ready       = adv[0];
   assign rsp_chan.valid       = vld_ff[NST-1];
   assign rsp_chan.out_x       = out_ff[0];
   assign rsp_chan.out_y       = out_ff[1];
   assign rsp_chan.out_z       = out_ff[2];
   assign rsp_chan.out_w       = outw_ff;
   assign rsp_chan.was_divided = div_ff;

`ifndef SYNTHESIS
   a_flag_w: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.was_divided == (rsp_chan.out_w != '0)))
      else $error("division flag disagrees with w");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> ((&vld_ff) && !rsp_chan.ready))
      else $error("input stalled with room in the pipeline");
   a_bad_index: assert property (@(posedge clock) disable iff (reset)
      (csr_we && (csr_index >= CSR_IDX_W'(NUM_REGS))) |=> $stable(regs_ff[0]))
      else $error("write beyond the register list changed a register");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !vld_ff[NST-2]) |=> !rsp_chan.valid)
      else $error("item delivered twice");
`endif
endmodule
